// ===== sv/arq_pkg.sv =====
// shared types, widths and codes of the arq sliding window sender
`timescale 1ns / 1ps

package arq_pkg;

  // sizing
  localparam int MAX_PACKETS = 1024;
  localparam int MAX_WINDOW  = 32;

  localparam int PKT_W     = $clog2(MAX_PACKETS);
  localparam int SEQ_W     = PKT_W + 1;
  localparam int WIN_W     = 6;
  localparam int MODE_W    = 2;
  localparam int KIND_W    = 2;
  localparam int CFG_W     = SEQ_W;
  localparam int REG_IDX_W = 2;

  // ack bitmap organized as rows of bits, one valid flop per row
  localparam int ROW_BITS = (MAX_PACKETS < 32) ? MAX_PACKETS : 32;
  localparam int BIT_W    = $clog2(ROW_BITS);
  localparam int ROWS     = MAX_PACKETS / ROW_BITS;
  localparam int ROW_AW   = (ROWS > 1) ? $clog2(ROWS) : 1;

  // configuration register indexes
  typedef enum logic [REG_IDX_W-1:0] {
    REG_ARQ_MODE      = 2'd0,
    REG_TOTAL_PACKETS = 2'd1,
    REG_WINDOW_SIZE   = 2'd2
  } reg_index_t;

  // arq modes
  localparam logic [MODE_W-1:0] MODE_STOP_WAIT  = 2'd0;
  localparam logic [MODE_W-1:0] MODE_GO_BACK_N  = 2'd1;
  localparam logic [MODE_W-1:0] MODE_SEL_REPEAT = 2'd2;

  // event kinds on the input channel
  localparam logic [KIND_W-1:0] EV_START   = 2'd0;
  localparam logic [KIND_W-1:0] EV_ACK     = 2'd1;
  localparam logic [KIND_W-1:0] EV_TIMEOUT = 2'd2;

  // classified commands from front to back
  typedef enum logic [2:0] {
    CMD_START   = 3'd0,
    CMD_ACK     = 3'd1,
    CMD_RUN     = 3'd2,
    CMD_TIMEOUT = 3'd3,
    CMD_STATUS  = 3'd4
  } cmd_kind_t;

  typedef struct packed {
    cmd_kind_t        kind;
    logic [PKT_W-1:0] ack;
  } cmd_t;

  // effective configuration seen by front and back
  typedef struct packed {
    logic [MODE_W-1:0] mode;
    logic              sel;
    logic [SEQ_W-1:0]  total;
    logic [WIN_W-1:0]  win;
  } cfg_t;

  function automatic logic [ROW_AW-1:0] row_of(input logic [PKT_W-1:0] p);
    return ROW_AW'(p >> BIT_W);
  endfunction

  function automatic logic [BIT_W-1:0] bit_of(input logic [PKT_W-1:0] p);
    return p[BIT_W-1:0];
  endfunction

endpackage

// ===== sv/arq_if.sv =====
// event and result channel interfaces
`timescale 1ns / 1ps

interface arq_event_if import arq_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [KIND_W-1:0] kind;
  logic [PKT_W-1:0]  ack_number;

  modport source (output valid, kind, ack_number, input ready);
  modport sink (input valid, kind, ack_number, output ready);
endinterface

interface arq_result_if import arq_pkg::*; ();
  logic             valid;
  logic             ready;
  logic [PKT_W-1:0] packet_number;
  logic             packet_valid;
  logic             last_of_event;
  logic [SEQ_W-1:0] window_base;
  logic             finished;

  modport source (output valid, packet_number, packet_valid, last_of_event,
                  window_base, finished, input ready);
  modport sink (input valid, packet_number, packet_valid, last_of_event,
                window_base, finished, output ready);
endinterface

// ===== sv/arq_ram.sv =====
// generic single write port ram with registered read
`timescale 1ns / 1ps

module arq_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 32
) (
  input  logic                                    clk,
  input  logic                                    we,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                        wdata,
  input  logic                                    re,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                        rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // registered read, held when not reading
  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ===== sv/arq_front.sv =====
// event intake: classifies events and queues commands for the back end
`timescale 1ns / 1ps

module arq_front import arq_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  arq_event_if.sink   evt,
  input  cfg_t        cfg,
  output logic        cmd_valid,
  output cmd_t        cmd,
  input  logic        cmd_pop
);

  cmd_t       q [2];
  logic       wr_ptr;
  logic       rd_ptr;
  logic [1:0] count;
  logic       active;
  logic       accept;
  cmd_t       cmd_in;

  assign evt.ready = (count != 2'd2);
  assign accept    = evt.valid && evt.ready;

  // classify the incoming word
  always_comb begin
    cmd_in.ack = evt.ack_number;
    unique case (evt.kind)
      EV_START: cmd_in.kind = CMD_START;
      EV_ACK: begin
        if (!active) begin
          cmd_in.kind = CMD_STATUS;
        end else if (SEQ_W'(evt.ack_number) < cfg.total) begin
          cmd_in.kind = CMD_ACK;
        end else begin
          cmd_in.kind = CMD_RUN;
        end
      end
      EV_TIMEOUT: cmd_in.kind = active ? CMD_TIMEOUT : CMD_STATUS;
      default: cmd_in.kind = CMD_STATUS;
    endcase
  end

  // transfer running flag
  always_ff @(posedge clk) begin
    if (rst) begin
      active <= 1'b0;
    end else if (accept && evt.kind == EV_START) begin
      active <= 1'b1;
    end
  end

  // two entry command queue
  always_ff @(posedge clk) begin
    if (accept) begin
      q[wr_ptr] <= cmd_in;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (accept) begin
        wr_ptr <= ~wr_ptr;
      end
      if (cmd_pop) begin
        rd_ptr <= ~rd_ptr;
      end
      count <= count + 2'(accept) - 2'(cmd_pop);
    end
  end

  assign cmd_valid = (count != 2'd0);
  assign cmd       = q[rd_ptr];

  // checks
  a_count_bound: assert property (@(posedge clk) disable iff (rst) count <= 2'd2)
    else $error("command queue count out of range");
  a_pop_nonempty: assert property (@(posedge clk) disable iff (rst) cmd_pop |-> cmd_valid)
    else $error("pop from empty command queue");
  a_start_active: assert property (@(posedge clk) disable iff (rst)
    (accept && evt.kind == EV_START) |=> active)
    else $error("start did not set the running flag");

endmodule

// ===== sv/arq_back.sv =====
// window engine: applies commands, walks the ack bitmap, emits result words
`timescale 1ns / 1ps

module arq_back import arq_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  cfg_t        cfg,
  input  logic        cmd_valid,
  input  cmd_t        cmd,
  output logic        cmd_pop,
  arq_result_if.source res
);

  typedef enum logic [7:0] {
    S_IDLE     = 8'b0000_0001,
    S_MARK_RD  = 8'b0000_0010,
    S_MARK_WR  = 8'b0000_0100,
    S_WALK_RD  = 8'b0000_1000,
    S_WALK_CHK = 8'b0001_0000,
    S_SEND_RD  = 8'b0010_0000,
    S_SEND_CHK = 8'b0100_0000,
    S_STATUS   = 8'b1000_0000
  } state_t;

  state_t             state;
  logic [SEQ_W-1:0]   base;
  logic [SEQ_W-1:0]   next;
  logic [PKT_W-1:0]   ack_reg;
  logic [ROWS-1:0]    row_valid;
  logic               rd_ok;

  logic               out_valid;
  logic [PKT_W-1:0]   out_pkt;
  logic               out_pv;
  logic               out_last;
  logic [SEQ_W-1:0]   out_base;
  logic               out_fin;

  logic               ram_re;
  logic [ROW_AW-1:0]  ram_raddr;
  logic [ROW_BITS-1:0] ram_rdata;
  logic               ram_we;
  logic [ROW_AW-1:0]  ram_waddr;
  logic [ROW_BITS-1:0] ram_wdata;

  logic               slot_free;
  logic [SEQ_W:0]     limit;
  logic               send_more;
  logic [PKT_W-1:0]   next_pkt;
  logic [PKT_W-1:0]   base_pkt;
  logic               hit_next;
  logic               hit_base;
  logic               emit_send;
  logic               emit_status;

  assign slot_free = !out_valid || res.ready;
  assign limit     = {1'b0, base} + (SEQ_W + 1)'(cfg.win);
  assign send_more = ({1'b0, next} < limit) && (next < cfg.total);
  assign next_pkt  = next[PKT_W-1:0];
  assign base_pkt  = base[PKT_W-1:0];
  assign hit_next  = rd_ok && ram_rdata[bit_of(next_pkt)];
  assign hit_base  = rd_ok && ram_rdata[bit_of(base_pkt)];

  assign emit_send   = (state == S_SEND_CHK) && !(cfg.sel && hit_next) && slot_free;
  assign emit_status = (state == S_STATUS) && slot_free;
  assign cmd_pop     = (state == S_IDLE) && cmd_valid;

  // bitmap port control
  always_comb begin
    ram_re    = 1'b0;
    ram_raddr = row_of(next_pkt);
    ram_we    = 1'b0;
    ram_waddr = row_of(ack_reg);
    ram_wdata = (rd_ok ? ram_rdata : '0) | (ROW_BITS'(1) << bit_of(ack_reg));
    unique case (state)
      S_MARK_RD: begin
        ram_re    = 1'b1;
        ram_raddr = row_of(ack_reg);
      end
      S_MARK_WR: ram_we = 1'b1;
      S_WALK_RD: begin
        ram_re    = (base < cfg.total);
        ram_raddr = row_of(base_pkt);
      end
      S_SEND_RD: ram_re = (next >= base) && send_more;
      default: ;
    endcase
  end

  arq_ram #(
    .WIDTH (ROW_BITS),
    .DEPTH (ROWS)
  ) u_ack_map (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  // sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      base      <= '0;
      next      <= '0;
      row_valid <= '0;
      rd_ok     <= 1'b0;
    end else begin
      if (ram_re) begin
        rd_ok <= row_valid[ram_raddr];
      end
      if (ram_we) begin
        row_valid[ram_waddr] <= 1'b1;
      end
      unique case (state)
        S_IDLE: begin
          if (cmd_valid) begin
            ack_reg <= cmd.ack;
            unique case (cmd.kind)
              CMD_START: begin
                row_valid <= '0;
                base      <= '0;
                next      <= '0;
                state     <= S_SEND_RD;
              end
              CMD_ACK: begin
                if (cfg.sel) begin
                  state <= S_MARK_RD;
                end else begin
                  if (cfg.mode == MODE_GO_BACK_N) begin
                    if (SEQ_W'(cmd.ack) >= base) begin
                      base <= SEQ_W'(cmd.ack) + SEQ_W'(1);
                    end
                  end else if (SEQ_W'(cmd.ack) == base) begin
                    base <= base + SEQ_W'(1);
                  end
                  state <= S_SEND_RD;
                end
              end
              CMD_RUN: state <= S_SEND_RD;
              CMD_TIMEOUT: begin
                next  <= base;
                state <= S_SEND_RD;
              end
              default: state <= S_STATUS;
            endcase
          end
        end
        S_MARK_RD: state <= S_MARK_WR;
        S_MARK_WR: state <= S_WALK_RD;
        S_WALK_RD: begin
          state <= (base < cfg.total) ? S_WALK_CHK : S_SEND_RD;
        end
        S_WALK_CHK: begin
          if (hit_base) begin
            base  <= base + SEQ_W'(1);
            state <= S_WALK_RD;
          end else begin
            state <= S_SEND_RD;
          end
        end
        S_SEND_RD: begin
          if (next < base) begin
            next <= base;
          end else if (send_more) begin
            state <= S_SEND_CHK;
          end else begin
            state <= S_STATUS;
          end
        end
        S_SEND_CHK: begin
          if ((cfg.sel && hit_next) || slot_free) begin
            next  <= next + SEQ_W'(1);
            state <= S_SEND_RD;
          end
        end
        S_STATUS: begin
          if (slot_free) begin
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (emit_send || emit_status) begin
      out_valid <= 1'b1;
    end else if (res.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (emit_send || emit_status) begin
      out_pkt  <= emit_send ? next_pkt : '0;
      out_pv   <= emit_send;
      out_last <= emit_status;
      out_base <= base;
      out_fin  <= (base >= cfg.total);
    end
  end

  assign res.valid         = out_valid;
  assign res.packet_number = out_pkt;
  assign res.packet_valid  = out_pv;
  assign res.last_of_event = out_last;
  assign res.window_base   = out_base;
  assign res.finished      = out_fin;

  // checks
  a_start_clears: assert property (@(posedge clk) disable iff (rst)
    (state == S_IDLE && cmd_valid && cmd.kind == CMD_START)
      |=> (row_valid == '0 && base == '0 && next == '0))
    else $error("start did not clear window state");
  a_send_in_range: assert property (@(posedge clk) disable iff (rst)
    emit_send |-> (next < cfg.total && next >= base))
    else $error("send outside the transfer or below base");
  a_send_in_window: assert property (@(posedge clk) disable iff (rst)
    emit_send |-> ({1'b0, next} < limit))
    else $error("send beyond the window");
  a_status_ends: assert property (@(posedge clk) disable iff (rst)
    emit_status |=> (state == S_IDLE && out_valid && out_last))
    else $error("status word did not close the event");

endmodule

// ===== sv/arq_sliding_window_sender.sv =====
// top level of the arq sliding window sender
`timescale 1ns / 1ps

// Sender side of a sliding window ARQ: stop-and-wait, go-back-N or
// selective repeat, chosen by the arq_mode register.
// Configuration: cfg_write with cfg_index 0 (arq_mode), 1 (total_packets),
// 2 (window_size) and cfg_data; write only while no event is in flight.
// Input channel evt: one word per event (start, ack received, timeout).
// Output channel res: one word per packet to send, then one status word
// with last_of_event set; every word carries window_base and finished.
// Sequence: an event is taken in idle, then each packet considered for
// sending passes a read state and a check state, set by the single read
// port of the ack bitmap ram; an event that only reports status goes
// straight to the status state. In selective repeat an ack first marks
// the ack bitmap (read, then write) and checks the base, with a read and
// a check for each acked packet the base steps over.
// A two entry command queue lets events be taken while the engine works.
// Reset clears base, next and the ack bitmap row flags at once; no
// clearing pass is needed. A stalled receiver holds the output register
// and the engine waits; the queue keeps taking events until it is full.

module arq_sliding_window_sender import arq_pkg::*; (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 cfg_write,
  input  logic [REG_IDX_W-1:0] cfg_index,
  input  logic [CFG_W-1:0]     cfg_data,
  arq_event_if.sink            evt,
  arq_result_if.source         res
);

  logic [MODE_W-1:0] arq_mode;
  logic [SEQ_W-1:0]  total_packets;
  logic [WIN_W-1:0]  window_size;
  cfg_t              cfg;
  logic              cmd_valid;
  cmd_t              cmd;
  logic              cmd_pop;

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      arq_mode      <= MODE_STOP_WAIT;
      total_packets <= '0;
      window_size   <= WIN_W'(1);
    end else if (cfg_write) begin
      unique case (cfg_index)
        REG_ARQ_MODE:      arq_mode      <= cfg_data[MODE_W-1:0];
        REG_TOTAL_PACKETS: total_packets <= cfg_data[SEQ_W-1:0];
        REG_WINDOW_SIZE:   window_size   <= cfg_data[WIN_W-1:0];
        default: ;
      endcase
    end
  end

  // effective total and window
  always_comb begin
    cfg.mode  = arq_mode;
    cfg.sel   = (arq_mode == MODE_SEL_REPEAT);
    cfg.total = (total_packets > SEQ_W'(MAX_PACKETS)) ? SEQ_W'(MAX_PACKETS)
                                                      : total_packets;
    if (arq_mode != MODE_GO_BACK_N && arq_mode != MODE_SEL_REPEAT) begin
      cfg.win = WIN_W'(1);
    end else if (window_size == '0) begin
      cfg.win = WIN_W'(1);
    end else if (window_size > WIN_W'(MAX_WINDOW)) begin
      cfg.win = WIN_W'(MAX_WINDOW);
    end else begin
      cfg.win = window_size;
    end
  end

  arq_front u_front (
    .clk       (clk),
    .rst       (rst),
    .evt       (evt),
    .cfg       (cfg),
    .cmd_valid (cmd_valid),
    .cmd       (cmd),
    .cmd_pop   (cmd_pop)
  );

  arq_back u_back (
    .clk       (clk),
    .rst       (rst),
    .cfg       (cfg),
    .cmd_valid (cmd_valid),
    .cmd       (cmd),
    .cmd_pop   (cmd_pop),
    .res       (res)
  );

endmodule
